[rtl/core/ctia_pkg.sv]
package ctia_pkg;

  typedef enum logic [4:0] {
    M_LAND = 5'd0, M_LOR = 5'd1, M_EQ = 5'd2, M_NE = 5'd3, M_LT = 5'd4, M_LE = 5'd5,
    M_GT = 5'd6, M_GE = 5'd7, M_ADD = 5'd8, M_SUB = 5'd9, M_MUL = 5'd10, M_DIV = 5'd11,
    M_MOD = 5'd12, M_AND = 5'd13, M_OR = 5'd14, M_XOR = 5'd15, M_SHL = 5'd16,
    M_SHR = 5'd17, M_NEG = 5'd18, M_COMPL = 5'd19, M_LNOT = 5'd20, M_CAST = 5'd21
  } mode_t;

  localparam int DivSteps = 4;
  localparam int DivStages = 64 / DivSteps;

  typedef struct packed {
    logic [4:0]  mode;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic        lhs_is_bool;
    logic        rhs_is_bool;
    logic [2:0]  operand_width;
    logic [1:0]  operand_class;
    logic [2:0]  result_width;
    logic [1:0]  result_class;
  } in_item_t;

  typedef struct packed {
    logic        folded;
    logic        result_is_bool;
    logic [63:0] value;
  } out_item_t;

  // decoded operation carried down the pipe
  typedef struct packed {
    logic        refuse;
    logic        done;
    logic        is_bool;
    logic [63:0] value;
    logic        is_mul;
    logic        is_div;
    logic        is_mod;
    logic        uns;
    logic        neg;
    logic        check_fit;
    logic [2:0]  result_width;
    logic [1:0]  result_class;
  } op_t;

  function automatic logic width_known(input logic [2:0] w);
    return (w >= 3'd1) && (w <= 3'd4);
  endfunction

  function automatic logic [6:0] width_bits(input logic [2:0] w);
    case (w)
      3'd1: return 7'd8;
      3'd2: return 7'd16;
      3'd3: return 7'd32;
      default: return 7'd64;
    endcase
  endfunction

  function automatic logic [63:0] wrap_width(input logic [2:0] w, input logic sgn,
                                             input logic [63:0] v);
    case (w)
      3'd1: return sgn ? {{56{v[7]}}, v[7:0]} : {56'd0, v[7:0]};
      3'd2: return sgn ? {{48{v[15]}}, v[15:0]} : {48'd0, v[15:0]};
      3'd3: return sgn ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
      default: return v;
    endcase
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

[rtl/core/ctia_decode.sv]
module ctia_decode (
  input  ctia_pkg::in_item_t it,
  output ctia_pkg::op_t      op,
  output logic [63:0]        opa,
  output logic [63:0]        opb
);
  import ctia_pkg::*;

  logic uns;
  logic [6:0] bits;
  logic [63:0] a, b, v, sa, sb;
  logic [64:0] ssum;

  always_comb begin
    a = it.lhs;
    b = it.rhs;
    uns = width_known(it.operand_width) && (it.operand_class == 2'd1);
    bits = width_known(it.operand_width) ? width_bits(it.operand_width) : 7'd64;
    sa = uns ? a : (a ^ {1'b1, 63'd0});
    sb = uns ? b : (b ^ {1'b1, 63'd0});
    ssum = 65'd0;
    v = 64'd0;
    op = '0;
    op.uns = uns;
    op.result_width = it.result_width;
    op.result_class = it.result_class;
    op.check_fit = 1'b1;
    opa = a;
    opb = b;
    if (it.mode >= 5'd22) begin
      op.refuse = 1'b1;
    end else if (it.mode == M_NEG) begin
      op.refuse = it.lhs_is_bool || (a == {1'b1, 63'd0});
      op.value = 64'd0 - a;
    end else if (it.mode == M_COMPL) begin
      op.refuse = it.lhs_is_bool;
      op.check_fit = 1'b0;
      op.value = wrap_width(it.result_width, it.result_class == 2'd0, ~a);
    end else if (it.mode == M_LNOT) begin
      op.refuse = !it.lhs_is_bool;
      op.is_bool = 1'b1;
      op.check_fit = 1'b0;
      op.value = {63'd0, a == 64'd0};
    end else if (it.mode == M_CAST) begin
      op.refuse = it.lhs_is_bool || !width_known(it.result_width) || it.result_class >= 2'd2;
      op.check_fit = 1'b0;
      op.value = wrap_width(it.result_width, it.result_class == 2'd0, a);
    end else if (it.lhs_is_bool && it.rhs_is_bool) begin
      op.is_bool = 1'b1;
      op.check_fit = 1'b0;
      case (it.mode)
        M_LAND: op.value = {63'd0, (a != 64'd0) && (b != 64'd0)};
        M_LOR:  op.value = {63'd0, (a != 64'd0) || (b != 64'd0)};
        M_EQ:   op.value = {63'd0, a == b};
        M_NE:   op.value = {63'd0, a != b};
        default: op.refuse = 1'b1;
      endcase
    end else if (it.lhs_is_bool || it.rhs_is_bool || it.mode <= M_LOR) begin
      op.refuse = 1'b1;
    end else begin
      case (it.mode)
        M_EQ: begin op.is_bool = 1'b1; op.check_fit = 1'b0; op.value = {63'd0, a == b}; end
        M_NE: begin op.is_bool = 1'b1; op.check_fit = 1'b0; op.value = {63'd0, a != b}; end
        M_LT: begin op.is_bool = 1'b1; op.check_fit = 1'b0; op.value = {63'd0, sa < sb}; end
        M_LE: begin op.is_bool = 1'b1; op.check_fit = 1'b0; op.value = {63'd0, sa <= sb}; end
        M_GT: begin op.is_bool = 1'b1; op.check_fit = 1'b0; op.value = {63'd0, sa > sb}; end
        M_GE: begin op.is_bool = 1'b1; op.check_fit = 1'b0; op.value = {63'd0, sa >= sb}; end
        M_ADD: begin
          ssum = {1'b0, a} + {1'b0, b};
          v = ssum[63:0];
          op.value = v;
          op.refuse = ((a[63] ^ v[63]) & (b[63] ^ v[63]));
        end
        M_SUB: begin
          v = a - b;
          op.value = v;
          op.refuse = ((a[63] ^ b[63]) & (a[63] ^ v[63]));
        end
        M_MUL: begin
          op.is_mul = 1'b1;
          op.neg = a[63] ^ b[63];
          opa = mag(a);
          opb = mag(b);
        end
        M_DIV, M_MOD: begin
          op.is_div = (it.mode == M_DIV);
          op.is_mod = (it.mode == M_MOD);
          op.refuse = (b == 64'd0) ||
                      (!uns && (a == {1'b1, 63'd0}) && (b == 64'hFFFF_FFFF_FFFF_FFFF));
          op.neg = uns ? 1'b0 : ((it.mode == M_DIV) ? (a[63] ^ b[63]) : a[63]);
          opa = uns ? a : mag(a);
          opb = uns ? b : mag(b);
          if (b == 64'd0) opb = 64'd1;
        end
        M_AND: op.value = a & b;
        M_OR:  op.value = a | b;
        M_XOR: op.value = a ^ b;
        M_SHL: begin
          op.refuse = b[63] || (b >= {57'd0, bits});
          op.value = a << b[5:0];
        end
        default: begin
          op.refuse = b[63] || (b >= {57'd0, bits});
          if (uns || !a[63]) op.value = a >> b[5:0];
          else op.value = ~((~a) >> b[5:0]);
        end
      endcase
    end
    op.done = !(op.is_mul || op.is_div || op.is_mod);
  end

endmodule

[rtl/core/ctia_divstage.sv]
module ctia_divstage (
  input  logic [63:0] num_in,
  input  logic [63:0] rem_in,
  input  logic [63:0] den,
  output logic [63:0] num_out,
  output logic [63:0] rem_out
);
  import ctia_pkg::*;

  logic [64:0] r;
  logic [63:0] n;

  always_comb begin
    n = num_in;
    r = {1'b0, rem_in};
    for (int i = 0; i < DivSteps; i++) begin
      r = {r[63:0], n[63]};
      n = {n[62:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        n[0] = 1'b1;
      end
    end
    num_out = n;
    rem_out = r[63:0];
  end

endmodule

[rtl/core/checked_typed_integer_alu.sv]
// Throughput: one transaction per cycle unless the output stalls; all modes share one path.
// The divider is a 16-stage radix-16 restoring pipe, and the 64x64 product is built
//   from four 32x32 partial products over two stages.
// A stall on the output freezes the whole pipe; the output register holds its transaction.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
module checked_typed_integer_alu (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ctia_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ctia_pkg::out_item_t  out_data
);
  import ctia_pkg::*;

  localparam int Depth = DivStages + 3;

  logic adv;
  op_t dec_op;
  logic [63:0] dec_a, dec_b;

  op_t         p_op  [Depth];
  logic [63:0] p_num [Depth];
  logic [63:0] p_rem [Depth];
  logic [63:0] p_den [Depth];
  logic        p_vld [Depth];
  logic [63:0] s_num [DivStages];
  logic [63:0] s_rem [DivStages];

  // multiply partials
  logic [63:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [127:0] prod;
  logic mul_ovf;
  op_t mul_op;

  ctia_decode u_dec (.it(in_data), .op(dec_op), .opa(dec_a), .opb(dec_b));

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 0: decode register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld[0] <= 1'b0;
    end else if (adv) begin
      p_vld[0] <= in_valid;
    end
    if (adv) begin
      p_op[0] <= dec_op;
      p_num[0] <= dec_a;
      p_den[0] <= dec_b;
      p_rem[0] <= 64'd0;
    end
  end

  // stage 1: 32x32 partial products (num, den still carried)
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld[1] <= 1'b0;
    end else if (adv) begin
      p_vld[1] <= p_vld[0];
    end
    if (adv) begin
      p_op[1] <= p_op[0];
      p_num[1] <= p_num[0];
      p_den[1] <= p_den[0];
      p_rem[1] <= 64'd0;
      pp_ll <= {32'd0, p_num[0][31:0]} * {32'd0, p_den[0][31:0]};
      pp_lh <= {32'd0, p_num[0][31:0]} * {32'd0, p_den[0][63:32]};
      pp_hl <= {32'd0, p_num[0][63:32]} * {32'd0, p_den[0][31:0]};
      pp_hh <= {32'd0, p_num[0][63:32]} * {32'd0, p_den[0][63:32]};
    end
  end

  assign prod = {64'd0, pp_ll} + {32'd0, pp_lh, 32'd0} + {32'd0, pp_hl, 32'd0}
                + {pp_hh, 64'd0};
  assign mul_ovf = (prod[127:64] != 64'd0) ||
                   (p_op[1].neg ? (prod[63:0] > {1'b1, 63'd0}) : prod[63]);

  always_comb begin
    mul_op = p_op[1];
    if (p_op[1].is_mul) begin
      mul_op.refuse = p_op[1].refuse | mul_ovf;
      mul_op.value = p_op[1].neg ? (64'd0 - prod[63:0]) : prod[63:0];
      mul_op.done = 1'b1;
    end
  end

  // stage 2: multiply finish
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld[2] <= 1'b0;
    end else if (adv) begin
      p_vld[2] <= p_vld[1];
    end
    if (adv) begin
      p_op[2] <= mul_op;
      p_num[2] <= p_num[1];
      p_den[2] <= p_den[1];
      p_rem[2] <= 64'd0;
    end
  end

  // divider stages
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    ctia_divstage u_ds (
      .num_in(p_num[g + 2]), .rem_in(p_rem[g + 2]), .den(p_den[g + 2]),
      .num_out(s_num[g]), .rem_out(s_rem[g])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        p_vld[g + 3] <= 1'b0;
      end else if (adv) begin
        p_vld[g + 3] <= p_vld[g + 2];
      end
      if (adv) begin
        p_op[g + 3] <= p_op[g + 2];
        p_num[g + 3] <= s_num[g];
        p_rem[g + 3] <= s_rem[g];
        p_den[g + 3] <= p_den[g + 2];
      end
    end
  end

  op_t lst;
  logic [63:0] fin_v;
  logic fin_ok;

  always_comb begin
    lst = p_op[Depth - 1];
    fin_v = lst.value;
    if (lst.is_div) fin_v = lst.neg ? (64'd0 - p_num[Depth - 1]) : p_num[Depth - 1];
    if (lst.is_mod) fin_v = lst.neg ? (64'd0 - p_rem[Depth - 1]) : p_rem[Depth - 1];
    fin_ok = !lst.refuse;
    if (lst.check_fit && width_known(lst.result_width) &&
        (wrap_width(lst.result_width, lst.result_class == 2'd0, fin_v) != fin_v))
      fin_ok = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_vld[Depth - 1];
    end
    if (adv) begin
      out_data.folded <= fin_ok;
      out_data.result_is_bool <= fin_ok & lst.is_bool;
      out_data.value <= fin_ok ? fin_v : 64'd0;
    end
  end

endmodule

[rtl/core/ctia_checker.sv]
module ctia_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input ctia_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input ctia_pkg::out_item_t out_data
);
  import ctia_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.folded |-> !out_data.result_is_bool && out_data.value == 64'd0)
    else $error("refused result not cleared");

  a_bool_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_is_bool |-> out_data.value[63:1] == 63'd0)
    else $error("bool result out of range");

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule

bind checked_typed_integer_alu ctia_checker u_chk (.*);
